>>> sv/euler_angles_to_basis_vectors_top_defines.svh
// Assertion macros of the Euler-angle basis vector top level.
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_TOP_DEFINES_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define EA2BV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define EA2BV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EA2BV_ASSERT(lbl, clk, rstn, prop)
`define EA2BV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> sv/ea2bv_pkg.sv
// Shared types, constants and arithmetic helpers of the basis vector block.
package ea2bv_pkg;

  localparam int DEFAULT_ANGLE_BITS    = 16;
  localparam int DEFAULT_FRACTION_BITS = 14;

  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  // sine/cosine unit: 3 front stages, 6 terms of 3 stages, 1 output stage
  localparam int SC_LAT   = 22;
  localparam int POST_LAT = 5;
  localparam int PIPE_LAT = SC_LAT + POST_LAT;

  localparam logic [32:0] HALF_PI_Q32 = 33'h1_921F_B544;
  localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } ctl_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } sc_t;

  typedef struct packed {
    logic        neg;
    logic [61:0] mag;
  } prod_t;

  function automatic logic [30:0] q30_mag(logic signed [31:0] v);
    logic signed [31:0] a;
    a = (v < 0) ? -v : v;
    return a[30:0];
  endfunction

  function automatic prod_t qmul_raw(logic signed [31:0] a, logic signed [31:0] b);
    prod_t p;
    p.neg = a[31] ^ b[31];
    p.mag = 62'(q30_mag(a)) * 62'(q30_mag(b));
    return p;
  endfunction

  function automatic logic signed [31:0] qround(prod_t p);
    logic [61:0] r;
    logic [31:0] m;
    r = (p.mag + 62'(64'd1 << 29)) >> 30;
    m = r[31:0];
    return p.neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [33:0] sx34(logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

endpackage

>>> sv/euler_angles_to_basis_vectors_top.sv
// Top level: Euler angles to forward, right and up unit vectors.
//
// Takes pitch, yaw and roll as unsigned binary angles (2^ANGLE_BITS per full
// turn; input bits above ANGLE_BITS are ignored) and returns the forward,
// right and up vectors as signed Q1.FRACTION_BITS values, +1.0 = 2^FRACTION_BITS,
// rounded to nearest and saturated at +/-1.0; only the low 16 bits are kept
// when the format is wider. One request enters per clock while the output is
// not stalled; each result passes the sine/cosine pipeline (six series
// terms of three stages each, plus angle folding) and five product stages.
// A stall on the output freezes the whole pipeline and stalls the input in
// the same cycle, so no request is lost or repeated. No state survives a
// request; reset only clears the valid bits.
`include "euler_angles_to_basis_vectors_top_defines.svh"
module euler_angles_to_basis_vectors_top #(
  parameter int ANGLE_BITS    = ea2bv_pkg::DEFAULT_ANGLE_BITS,
  parameter int FRACTION_BITS = ea2bv_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ea2bv_pkg::IN_W-1:0]         pitch_angle_i,
  input  logic [ea2bv_pkg::IN_W-1:0]         yaw_angle_i,
  input  logic [ea2bv_pkg::IN_W-1:0]         roll_angle_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ea2bv_pkg::OUT_W-1:0] forward_x_o,
  output logic signed [ea2bv_pkg::OUT_W-1:0] forward_y_o,
  output logic signed [ea2bv_pkg::OUT_W-1:0] forward_z_o,
  output logic signed [ea2bv_pkg::OUT_W-1:0] right_x_o,
  output logic signed [ea2bv_pkg::OUT_W-1:0] right_y_o,
  output logic signed [ea2bv_pkg::OUT_W-1:0] right_z_o,
  output logic signed [ea2bv_pkg::OUT_W-1:0] up_x_o,
  output logic signed [ea2bv_pkg::OUT_W-1:0] up_y_o,
  output logic signed [ea2bv_pkg::OUT_W-1:0] up_z_o
);
  import ea2bv_pkg::*;

  localparam int          SHIFT = 30 - FRACTION_BITS;
  localparam logic [34:0] HALF  = (35'(1) << SHIFT) >> 1;
  localparam logic [34:0] CAP   = 35'(1) << FRACTION_BITS;

  // Q30 value to output format: round magnitude, saturate, keep low bits
  function automatic logic [OUT_W-1:0] to_out(logic signed [33:0] v);
    logic        neg;
    logic [33:0] m;
    logic [34:0] rnd;
    logic [35:0] res;
    neg = v[33];
    m   = neg ? 34'(-v) : 34'(v);
    rnd = (35'(m) + HALF) >> SHIFT;
    if (rnd > CAP) rnd = CAP;
    res = neg ? -36'(rnd) : 36'(rnd);
    return res[OUT_W-1:0];
  endfunction

  logic                en;
  logic [PIPE_LAT-1:0] vld_q;

  // whole pipeline advances unless a finished result is held back
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  sc_t sc_p, sc_y, sc_r;

  ea2bv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_pitch (
    .clk_i(clk_i), .en_i(en), .angle_i(pitch_angle_i), .sc_o(sc_p)
  );
  ea2bv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_yaw (
    .clk_i(clk_i), .en_i(en), .angle_i(yaw_angle_i), .sc_o(sc_y)
  );
  ea2bv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_roll (
    .clk_i(clk_i), .en_i(en), .angle_i(roll_angle_i), .sc_o(sc_r)
  );

  // stage 1: pairwise products
  prod_t p_cpcy_q, p_cpsy_q, p_crsy_q, p_crcy_q, p_srcp_q;
  prod_t p_crcp_q, p_srsy_q, p_srcy_q, p_srsp_q, p_crsp_q;
  logic signed [31:0] sp1_q, sy1_q, cy1_q;
  // stage 2: rounded pairs
  logic signed [31:0] r_cpcy_q, r_cpsy_q, r_crsy_q, r_crcy_q, r_srcp_q;
  logic signed [31:0] r_crcp_q, r_srsy_q, r_srcy_q, r_srsp_q, r_crsp_q;
  logic signed [31:0] sp2_q, sy2_q, cy2_q;
  // stage 3: triple products, pairs carried along
  prod_t t_a_q, t_b_q, t_c_q, t_d_q;
  logic signed [31:0] h_cpcy_q, h_cpsy_q, h_crsy_q, h_crcy_q;
  logic signed [31:0] h_srcp_q, h_crcp_q, h_srsy_q, h_srcy_q, sp3_q;
  // stage 4: component sums in Q30
  logic signed [33:0] v_fx_q, v_fy_q, v_fz_q, v_rx_q, v_ry_q, v_rz_q;
  logic signed [33:0] v_ux_q, v_uy_q, v_uz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_cpcy_q <= qmul_raw(sc_p.c, sc_y.c);
      p_cpsy_q <= qmul_raw(sc_p.c, sc_y.s);
      p_crsy_q <= qmul_raw(sc_r.c, sc_y.s);
      p_crcy_q <= qmul_raw(sc_r.c, sc_y.c);
      p_srcp_q <= qmul_raw(sc_r.s, sc_p.c);
      p_crcp_q <= qmul_raw(sc_r.c, sc_p.c);
      p_srsy_q <= qmul_raw(sc_r.s, sc_y.s);
      p_srcy_q <= qmul_raw(sc_r.s, sc_y.c);
      p_srsp_q <= qmul_raw(sc_r.s, sc_p.s);
      p_crsp_q <= qmul_raw(sc_r.c, sc_p.s);
      sp1_q    <= sc_p.s;
      sy1_q    <= sc_y.s;
      cy1_q    <= sc_y.c;

      r_cpcy_q <= qround(p_cpcy_q);
      r_cpsy_q <= qround(p_cpsy_q);
      r_crsy_q <= qround(p_crsy_q);
      r_crcy_q <= qround(p_crcy_q);
      r_srcp_q <= qround(p_srcp_q);
      r_crcp_q <= qround(p_crcp_q);
      r_srsy_q <= qround(p_srsy_q);
      r_srcy_q <= qround(p_srcy_q);
      r_srsp_q <= qround(p_srsp_q);
      r_crsp_q <= qround(p_crsp_q);
      sp2_q    <= sp1_q;
      sy2_q    <= sy1_q;
      cy2_q    <= cy1_q;

      t_a_q    <= qmul_raw(r_srsp_q, cy2_q);
      t_b_q    <= qmul_raw(r_srsp_q, sy2_q);
      t_c_q    <= qmul_raw(r_crsp_q, cy2_q);
      t_d_q    <= qmul_raw(r_crsp_q, sy2_q);
      h_cpcy_q <= r_cpcy_q;
      h_cpsy_q <= r_cpsy_q;
      h_crsy_q <= r_crsy_q;
      h_crcy_q <= r_crcy_q;
      h_srcp_q <= r_srcp_q;
      h_crcp_q <= r_crcp_q;
      h_srsy_q <= r_srsy_q;
      h_srcy_q <= r_srcy_q;
      sp3_q    <= sp2_q;

      v_fx_q <= sx34(h_cpcy_q);
      v_fy_q <= sx34(h_cpsy_q);
      v_fz_q <= -sx34(sp3_q);
      v_rx_q <= sx34(h_crsy_q) - sx34(qround(t_a_q));
      v_ry_q <= -sx34(qround(t_b_q)) - sx34(h_crcy_q);
      v_rz_q <= -sx34(h_srcp_q);
      v_ux_q <= sx34(qround(t_c_q)) + sx34(h_srsy_q);
      v_uy_q <= sx34(qround(t_d_q)) - sx34(h_srcy_q);
      v_uz_q <= sx34(h_crcp_q);

      forward_x_o <= to_out(v_fx_q);
      forward_y_o <= to_out(v_fy_q);
      forward_z_o <= to_out(v_fz_q);
      right_x_o   <= to_out(v_rx_q);
      right_y_o   <= to_out(v_ry_q);
      right_z_o   <= to_out(v_rz_q);
      up_x_o      <= to_out(v_ux_q);
      up_y_o      <= to_out(v_uy_q);
      up_z_o      <= to_out(v_uz_q);
    end
  end

  `EA2BV_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_valid_i && !in_stall_o, vld_q[0])
  `EA2BV_ASSERT_NEXT(a_idle_bubble, clk_i, rst_ni, !in_valid_i && !in_stall_o, !vld_q[0])
  `EA2BV_ASSERT_NEXT(a_stall_freezes, clk_i, rst_ni, in_stall_o, $stable(vld_q))

endmodule

>>> sv/ea2bv_sincos.sv
// Pipelined sine/cosine of one binary angle, Q30 results.
module ea2bv_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ea2bv_pkg::IN_W-1:0] angle_i,
  output ea2bv_pkg::sc_t             sc_o
);
  import ea2bv_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int RW = AB - 2;
  localparam logic [AB-2:0] QTR   = (AB-1)'(1) << (AB - 2);
  localparam logic [RW-1:0] HALFQ = RW'(1) << (AB - 3);
  localparam int CTL_N = 21;

  logic [AB-1:0] a;
  logic [RW-1:0] r, t;
  logic          swap;
  logic [31:0]   u;

  assign a    = AB'(angle_i);
  assign r    = a[RW-1:0];
  assign swap = r > HALFQ;
  assign t    = swap ? RW'(QTR - (AB-1)'(r)) : r;
  assign u    = 32'(t) << (34 - AB);

  ctl_t        ctl_q [CTL_N];
  logic [64:0] uprod_q;
  logic [31:0] x_q, x3_q;
  logic [63:0] xx_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q[0] <= '{quad: a[AB-1:AB-2], swap: swap};
      for (int i = 1; i < CTL_N; i++) ctl_q[i] <= ctl_q[i-1];
      uprod_q <= 65'(u) * 65'(HALF_PI_Q32);
      x_q     <= 32'((uprod_q + 65'(64'd1 << 31)) >> 32);
      xx_q    <= 64'(x_q) * 64'(x_q);
      x3_q    <= x_q;
    end
  end

  // series chain between term stages
  logic [32:0] s_term_w [7];
  logic [32:0] c_term_w [7];
  logic [32:0] s_sum_w  [7];
  logic [32:0] c_sum_w  [7];
  logic [31:0] x2_w     [7];

  assign s_term_w[0] = 33'(x3_q);
  assign s_sum_w[0]  = 33'(x3_q);
  assign c_term_w[0] = ONE_Q32;
  assign c_sum_w[0]  = ONE_Q32;
  assign x2_w[0]     = xx_q[63:32];

  for (genvar k = 1; k <= 6; k++) begin : g_term
    localparam logic [7:0]  SD = 8'(2 * k * (2 * k + 1));
    localparam logic [7:0]  CD = 8'((2 * k - 1) * (2 * k));
    localparam logic [31:0] SM = 32'((64'd1 << 32) / SD);
    localparam logic [31:0] CM = 32'((64'd1 << 32) / CD);

    logic [65:0] a_sp_q, a_cp_q;
    logic [32:0] a_ss_q, a_cs_q, b_ss_q, b_cs_q, c_st_q, c_ct_q, c_ss_q, c_cs_q;
    logic [31:0] a_x2_q, b_x2_q, c_x2_q, b_sn_q, b_cn_q;
    logic [63:0] b_sm_q, b_cm_q;
    logic [31:0] s_q0, c_q0, s_qq, c_qq;
    logic [39:0] s_rem, c_rem;

    // trial quotient from the reciprocal, then one correction step
    always_comb begin
      s_q0  = b_sm_q[63:32];
      c_q0  = b_cm_q[63:32];
      s_rem = 40'(b_sn_q) - 40'(s_q0) * 40'(SD);
      c_rem = 40'(b_cn_q) - 40'(c_q0) * 40'(CD);
      s_qq  = s_q0 + 32'(s_rem >= 40'(SD));
      c_qq  = c_q0 + 32'(c_rem >= 40'(CD));
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_sp_q <= 66'(s_term_w[k-1]) * 66'(x2_w[k-1]);
        a_cp_q <= 66'(c_term_w[k-1]) * 66'(x2_w[k-1]);
        a_ss_q <= s_sum_w[k-1];
        a_cs_q <= c_sum_w[k-1];
        a_x2_q <= x2_w[k-1];
        b_sn_q <= a_sp_q[63:32];
        b_cn_q <= a_cp_q[63:32];
        b_sm_q <= 64'(a_sp_q[63:32]) * 64'(SM);
        b_cm_q <= 64'(a_cp_q[63:32]) * 64'(CM);
        b_ss_q <= a_ss_q;
        b_cs_q <= a_cs_q;
        b_x2_q <= a_x2_q;
        c_st_q <= 33'(s_qq);
        c_ct_q <= 33'(c_qq);
        c_ss_q <= (k % 2 == 1) ? b_ss_q - 33'(s_qq) : b_ss_q + 33'(s_qq);
        c_cs_q <= (k % 2 == 1) ? b_cs_q - 33'(c_qq) : b_cs_q + 33'(c_qq);
        c_x2_q <= b_x2_q;
      end
    end

    assign s_term_w[k] = c_st_q;
    assign c_term_w[k] = c_ct_q;
    assign s_sum_w[k]  = c_ss_q;
    assign c_sum_w[k]  = c_cs_q;
    assign x2_w[k]     = c_x2_q;
  end

  logic signed [31:0] s30, c30, so, co;
  ctl_t               ctl;
  sc_t                sc_q;

  always_comb begin
    ctl = ctl_q[CTL_N-1];
    s30 = $signed(32'((34'(s_sum_w[6]) + 34'd2) >> 2));
    c30 = $signed(32'((34'(c_sum_w[6]) + 34'd2) >> 2));
    if (ctl.swap) begin
      so = c30;
      co = s30;
    end else begin
      so = s30;
      co = c30;
    end
  end

  // place the folded result in its quadrant
  function automatic sc_t place(ctl_t c, logic signed [31:0] s, logic signed [31:0] k);
    sc_t o;
    case (c.quad)
      2'd0:    o = '{s: s,  c: k};
      2'd1:    o = '{s: k,  c: -s};
      2'd2:    o = '{s: -s, c: -k};
      default: o = '{s: -k, c: s};
    endcase
    return o;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) sc_q <= place(ctl, so, co);
  end

  assign sc_o = sc_q;

endmodule

>>> tb/testbench.sv
// Self-checking bench for the Euler-angle to basis vector block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT = ea2bv_pkg::PIPE_LAT;

  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] roll;
  } angles_t;

  typedef struct packed {
    logic [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
  } basis_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] pitch_angle_i = '0, yaw_angle_i = '0, roll_angle_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] forward_x_o, forward_y_o, forward_z_o;
  logic signed [15:0] right_x_o, right_y_o, right_z_o;
  logic signed [15:0] up_x_o, up_y_o, up_z_o;

  euler_angles_to_basis_vectors_top dut (.*);

  // Clock: 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  angles_t pending_requests[$];
  basis_t  expected_bases[$];
  int      error_count = 0;
  int      send_idle_pct = 17;
  int      recv_idle_pct = 60;
  bit      hold_off = 1'b0;
  bit      in_taken = 1'b0;

  // Series sine/cosine on a folded angle, Q0.32 in, Q0.32 out.
  function automatic void series_sincos(input logic [63:0] x,
                                        output logic [63:0] sv,
                                        output logic [63:0] cv);
    logic [63:0] x2, term, acc;
    logic [127:0] wide;
    x2 = (x * x) >> 32;
    term = x;
    acc = x;
    for (int k = 1; k <= 6; k++) begin
      wide = 128'(term) * 128'(x2);
      term = (wide >> 32) / ((2 * k) * (2 * k + 1));
      if (k & 1) acc = acc - term;
      else acc = acc + term;
    end
    sv = acc;
    term = 64'h1_0000_0000;
    acc = term;
    for (int k = 1; k <= 6; k++) begin
      wide = 128'(term) * 128'(x2);
      term = (wide >> 32) / ((2 * k - 1) * (2 * k));
      if (k & 1) acc = acc - term;
      else acc = acc + term;
    end
    cv = acc;
  endfunction

  // Binary angle to Q30 sine and cosine, quadrant folded.
  function automatic void angle_to_sc(input logic [15:0] a,
                                      output longint s_o, output longint c_o);
    logic [1:0]  quad;
    logic [13:0] rem;
    logic [63:0] t, x, s32, c32;
    longint s, c, tmp;
    quad = a[15:14];
    rem = a[13:0];
    t = rem;
    if (rem > 14'd8192) t = 64'd16384 - rem;
    x = ((t << 18) * 64'h1_921F_B544 + 64'h8000_0000) >> 32;
    series_sincos(x, s32, c32);
    s = longint'((s32 + 2) >> 2);
    c = longint'((c32 + 2) >> 2);
    if (rem > 14'd8192) begin
      tmp = s; s = c; c = tmp;
    end
    case (quad)
      2'd0: begin s_o = s;  c_o = c;  end
      2'd1: begin s_o = c;  c_o = -s; end
      2'd2: begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s; end
    endcase
  endfunction

  // Q30 product on magnitudes, round half away from zero.
  function automatic longint q30_product(longint a, longint b);
    longint ma, mb, p;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (ma * mb + (64'sd1 <<< 29)) >>> 30;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic logic [15:0] to_q14(longint v);
    longint mag;
    mag = v < 0 ? -v : v;
    mag = (mag + (64'sd1 <<< 15)) >>> 16;
    if (mag > 16384) mag = 16384;
    return 16'(v < 0 ? -mag : mag);
  endfunction

  function automatic basis_t predict_basis(angles_t in);
    longint sp, cp, sy, cy, sr, cr, srsp, crsp;
    basis_t b;
    angle_to_sc(in.pitch, sp, cp);
    angle_to_sc(in.yaw, sy, cy);
    angle_to_sc(in.roll, sr, cr);
    srsp = q30_product(sr, sp);
    crsp = q30_product(cr, sp);
    b.fx = to_q14(q30_product(cp, cy));
    b.fy = to_q14(q30_product(cp, sy));
    b.fz = to_q14(-sp);
    b.rx = to_q14(-q30_product(srsp, cy) + q30_product(cr, sy));
    b.ry = to_q14(-q30_product(srsp, sy) - q30_product(cr, cy));
    b.rz = to_q14(-q30_product(sr, cp));
    b.ux = to_q14(q30_product(crsp, cy) + q30_product(sr, sy));
    b.uy = to_q14(q30_product(crsp, sy) - q30_product(sr, cy));
    b.uz = to_q14(q30_product(cr, cp));
    return b;
  endfunction

  // Record whether the input handshake completed at this rising edge.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  // Driver: change inputs on the falling edge; hold a request until taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        // Request went in at the last rising edge; predict it and drop it.
        expected_bases.push_back(predict_basis(pending_requests.pop_front()));
      end
      if (!in_valid_i || in_taken) begin
        // Advance to the next request, or idle now and then.
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          pitch_angle_i <= pending_requests[0].pitch;
          yaw_angle_i <= pending_requests[0].yaw;
          roll_angle_i <= pending_requests[0].roll;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: a long hold-off wins over random stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long hold-off: pipeline fills and must stall its input.
  initial begin
    wait (rst_ni === 1'b1);
    repeat (40) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (3 * LAT) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    basis_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {forward_x_o, forward_y_o, forward_z_o, right_x_o, right_y_o,
             right_z_o, up_x_o, up_y_o, up_z_o};
      if (expected_bases.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = expected_bases.pop_front();
        if (got.fx !== want.fx) begin
          $display("%0t: forward_x expected %h got %h", $time, want.fx, got.fx); error_count++;
        end
        if (got.fy !== want.fy) begin
          $display("%0t: forward_y expected %h got %h", $time, want.fy, got.fy); error_count++;
        end
        if (got.fz !== want.fz) begin
          $display("%0t: forward_z expected %h got %h", $time, want.fz, got.fz); error_count++;
        end
        if (got.rx !== want.rx) begin
          $display("%0t: right_x expected %h got %h", $time, want.rx, got.rx); error_count++;
        end
        if (got.ry !== want.ry) begin
          $display("%0t: right_y expected %h got %h", $time, want.ry, got.ry); error_count++;
        end
        if (got.rz !== want.rz) begin
          $display("%0t: right_z expected %h got %h", $time, want.rz, got.rz); error_count++;
        end
        if (got.ux !== want.ux) begin
          $display("%0t: up_x expected %h got %h", $time, want.ux, got.ux); error_count++;
        end
        if (got.uy !== want.uy) begin
          $display("%0t: up_y expected %h got %h", $time, want.uy, got.uy); error_count++;
        end
        if (got.uz !== want.uz) begin
          $display("%0t: up_z expected %h got %h", $time, want.uz, got.uz); error_count++;
        end
      end
    end
  end

  function automatic logic [15:0] pick_angle();
    // Favor quadrant edges and the half-quadrant fold point now and then.
    case ($urandom_range(5))
      0: return 16'({$urandom_range(3), 14'd0} + $urandom_range(2) - 1);
      1: return 16'({$urandom_range(3), 14'd8192} + $urandom_range(2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_valid_i || expected_bases.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    angles_t a;
    logic [15:0] corner[8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                               16'hC000, 16'h2000, 16'h2001, 16'h5555};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // Directed: quadrant boundaries, fold point, all-ones and gimbal-lock pitch.
    for (int i = 0; i < 8; i++) begin
      a.pitch = corner[i];
      a.yaw = corner[(i + 3) % 8];
      a.roll = corner[(i + 5) % 8];
      pending_requests.push_back(a);
    end
    pending_requests.push_back(angles_t'{16'h4000, 16'h1234, 16'hABCD});
    pending_requests.push_back(angles_t'{16'hC000, 16'hFFFF, 16'h0000});
    pending_requests.push_back(angles_t'{16'hAAAA, 16'h5555, 16'hFFFF});
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 60; recv_idle_pct = 17; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int i = 0; i < 330; i++) begin
        a.pitch = pick_angle();
        a.yaw = pick_angle();
        a.roll = pick_angle();
        pending_requests.push_back(a);
      end
      wait_drained();
    end
    repeat (LAT + 5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("euler_angles_to_basis_vectors_top verification clean");
    end else begin
      $display("euler_angles_to_basis_vectors_top verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("euler_angles_to_basis_vectors_top verification failed");
    $finish;
  end

endmodule
